// ===== rtl/fss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the fair-share priority scheduler.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int unsigned MAX_JOBS_DEF   = 16;
  localparam int unsigned MAX_GROUPS_DEF = 16;

  localparam int unsigned TIME_W  = 24;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned PRIO_W  = 20;
  localparam int unsigned STAMP_W = 16;
  localparam int unsigned SLICE_W = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned BASE_W  = 7;

  localparam logic [TIME_W-1:0]  TIME_MAX     = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX      = '1;
  localparam logic [PRIO_W-1:0]  PRIO_MAX     = '1;
  localparam logic [SLICE_W-1:0] SLICE_RESET  = 16'd10;

  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_ADMIT = 3'd1,
    REQ_PICK  = 3'd2,
    REQ_EXEC  = 3'd3,
    REQ_EARLY = 3'd4
  } req_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         slot;
    logic [3:0]         group_id;
    logic [BASE_W-1:0]  base_priority;
    logic [TIME_W-1:0]  time_value;
    logic [TIME_W-1:0]  prev_decision_point;
    logic [BURST_W-1:0] burst_length;
    logic [15:0]        io_length;
    logic               is_last_burst;
  } in_req_t;

  typedef struct packed {
    logic              found;
    logic [3:0]        slot_out;
    logic [PRIO_W-1:0] priority_out;
    logic [TIME_W-1:0] new_time;
    logic              burst_finished;
    logic              job_done;
    logic [TIME_W-1:0] next_arrival;
  } out_res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } seq_stat_t;

endpackage

// ===== rtl/fss_prio_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_prio_unit
// Shared priority unit: halves the usage counts and forms the fair-share
// priority base + cpu/2 + group*groups/4, saturated.
// ----------------------------------------------------------------------------
module fss_prio_unit #(
  parameter int unsigned CW = 5
) (
  input  logic [fss_pkg::CNT_W-1:0]  cpu_i,
  input  logic [fss_pkg::CNT_W-1:0]  gu_i,
  input  logic [fss_pkg::BASE_W-1:0] base_i,
  input  logic [CW-1:0]              groups_i,
  output logic [fss_pkg::CNT_W-1:0]  cpu_half_o,
  output logic [fss_pkg::CNT_W-1:0]  gu_half_o,
  output logic [fss_pkg::PRIO_W-1:0] prio_o
);

  localparam int unsigned HW = fss_pkg::CNT_W - 1;
  localparam int unsigned PW = HW + CW;
  localparam int unsigned SW = (PW + 1 > fss_pkg::PRIO_W + 1) ? PW + 1 : fss_pkg::PRIO_W + 1;

  logic [HW-1:0] cpu_h;
  logic [HW-1:0] gu_h;
  logic [PW-1:0] prod;
  logic [SW-1:0] sum;

  assign cpu_h = cpu_i[fss_pkg::CNT_W-1:1];
  assign gu_h  = gu_i[fss_pkg::CNT_W-1:1];
  assign prod  = PW'(gu_h) * PW'(groups_i);
  assign sum   = SW'(base_i) + SW'(cpu_h >> 1) + SW'(prod >> 2);

  assign cpu_half_o = {1'b0, cpu_h};
  assign gu_half_o  = {1'b0, gu_h};
  assign prio_o     = (sum > SW'(fss_pkg::PRIO_MAX)) ? fss_pkg::PRIO_MAX
                                                     : sum[fss_pkg::PRIO_W-1:0];

endmodule

// ===== rtl/fss_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_seq
// Job table and the sequencer that scans it one slot per cycle.
// ----------------------------------------------------------------------------
module fss_seq #(
  parameter int unsigned MaxJobs   = fss_pkg::MAX_JOBS_DEF,
  parameter int unsigned MaxGroups = fss_pkg::MAX_GROUPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  fss_pkg::in_req_t               req_i,
  input  logic [fss_pkg::SLICE_W-1:0]    time_slice_i,
  input  logic                           res_ack_i,
  output fss_pkg::seq_stat_t             stat_o,
  output fss_pkg::out_res_t              res_o
);

  localparam int unsigned IW = $clog2(MaxJobs);
  localparam int unsigned GW = (MaxGroups > 1) ? $clog2(MaxGroups) : 1;
  localparam int unsigned CW = $clog2(MaxGroups + 1);
  localparam int unsigned TW = fss_pkg::TIME_W;
  localparam int unsigned NW = fss_pkg::CNT_W;
  localparam int unsigned SW = fss_pkg::STAMP_W;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LOAD   = 13'b0000000000010,
    S_ADM    = 13'b0000000000100,
    S_BIOF   = 13'b0000000001000,
    S_BIOD   = 13'b0000000010000,
    S_PICK   = 13'b0000000100000,
    S_EARLY  = 13'b0000001000000,
    S_EXCHK  = 13'b0000010000000,
    S_EXCHG  = 13'b0000100000000,
    S_EXUPD  = 13'b0001000000000,
    S_EXGRP  = 13'b0010000000000,
    S_EXPRIO = 13'b0100000000000,
    S_RESP   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // table
  logic                         slot_valid_q [MaxJobs];
  logic                         in_ready_q   [MaxJobs];
  logic [SW-1:0]                stamp_q      [MaxJobs];
  logic [GW-1:0]                grp_q        [MaxJobs];
  logic [fss_pkg::BASE_W-1:0]   base_q       [MaxJobs];
  logic [TW-1:0]                arr_q        [MaxJobs];
  logic [fss_pkg::BURST_W-1:0]  burst_q      [MaxJobs];
  logic [NW-1:0]                cpu_q        [MaxJobs];
  logic [NW-1:0]                gu_q         [MaxJobs];
  logic [fss_pkg::PRIO_W-1:0]   prio_q       [MaxJobs];
  logic                         bio_q        [MaxJobs];

  logic [SW-1:0]                counter_q;
  logic [IW-1:0]                idx_q;
  fss_pkg::in_req_t             req_q;
  fss_pkg::out_res_t            res_q;
  fss_pkg::out_res_t            res_init;
  logic                         bf_q;
  logic [IW-1:0]                bidx_q;
  logic [SW-1:0]                bage_q;
  logic [TW-1:0]                bval_q;
  logic [SW-1:0]                snap_q;
  logic [IW-1:0]                bio_idx_q;
  logic [GW-1:0]                bio_grp_q;
  logic [fss_pkg::SLICE_W-1:0]  run_q;
  logic                         done_q;
  logic [TW-1:0]                now_q;
  logic [IW-1:0]                tgt_q;
  logic [GW-1:0]                tgrp_q;
  logic [CW-1:0]                groups_q;
  logic [MaxGroups-1:0]         seen_q;

  // element under the scan pointer
  logic                         e_v, e_r, e_bio, e_qual, last;
  logic [GW-1:0]                e_grp;
  logic [TW-1:0]                e_arr;
  logic [fss_pkg::BURST_W-1:0]  e_burst;
  logic [NW-1:0]                e_cpu, e_gu;
  logic [SW-1:0]                e_age, age_ref;
  logic [TW-1:0]                e_key;
  logic                         cand, better, take;
  logic                         nb_found;
  logic [IW-1:0]                nb_idx;
  logic [TW-1:0]                nb_val;

  logic                         slot_ok;
  logic [IW-1:0]                slot_idx;
  logic [GW-1:0]                grp_in;
  logic [fss_pkg::SLICE_W-1:0]  run_c;
  logic [TW:0]                  now_sum, io_sum;
  logic [NW:0]                  chg_sum, cpu_sum;
  logic [NW-1:0]                pu_cpu, pu_gu;
  logic [fss_pkg::PRIO_W-1:0]   pu_prio;

  assign slot_ok  = 32'(req_i.slot) < MaxJobs;
  assign slot_idx = IW'(req_i.slot);
  assign grp_in   = (32'(req_q.group_id) < MaxGroups) ? GW'(req_q.group_id)
                                                      : GW'(MaxGroups - 1);

  assign last    = (idx_q == IW'(MaxJobs - 1));
  assign e_v     = slot_valid_q[idx_q];
  assign e_r     = in_ready_q[idx_q];
  assign e_bio   = bio_q[idx_q];
  assign e_grp   = grp_q[idx_q];
  assign e_arr   = arr_q[idx_q];
  assign e_burst = burst_q[idx_q];
  assign e_cpu   = cpu_q[idx_q];
  assign e_gu    = gu_q[idx_q];
  assign age_ref = (state_q == S_ADM) ? snap_q : counter_q;
  assign e_age   = age_ref - stamp_q[idx_q];
  assign e_qual  = e_v && e_r && (e_arr <= req_q.prev_decision_point);

  // execute results carry the request time until the run is known
  always_comb begin
    res_init = '0;
    if (req_i.req_type == fss_pkg::REQ_EXEC) begin
      res_init.new_time = req_i.time_value;
    end
  end

  always_comb begin
    cand   = 1'b0;
    better = 1'b0;
    e_key  = '0;
    unique case (state_q)
      S_ADM: begin
        cand   = e_v && !e_r && (e_arr <= req_q.time_value);
        better = !bf_q || (e_age > bage_q);
      end
      S_BIOF: begin
        cand   = e_v && e_r && e_bio;
        better = !bf_q || (e_age > bage_q);
        e_key  = TW'(e_grp);
      end
      S_BIOD: begin
        cand   = e_v && e_r && !e_bio && (e_grp == bio_grp_q);
        better = !bf_q || (e_age > bage_q);
        e_key  = TW'(e_gu);
      end
      S_PICK: begin
        cand   = e_v && e_r;
        e_key  = TW'(prio_q[idx_q]);
        better = !bf_q || (e_key < bval_q) || ((e_key == bval_q) && (e_age > bage_q));
      end
      S_EARLY: begin
        cand   = e_v && !e_r;
        e_key  = e_arr;
        better = !bf_q || (e_arr < bval_q);
      end
      default: begin
        cand = 1'b0;
      end
    endcase
  end

  assign take     = cand && better;
  assign nb_found = bf_q || take;
  assign nb_idx   = take ? idx_q : bidx_q;
  assign nb_val   = take ? e_key : bval_q;

  assign run_c   = (e_burst <= time_slice_i) ? e_burst : time_slice_i;
  assign now_sum = {1'b0, req_q.time_value} + (TW + 1)'(run_c);
  assign io_sum  = {1'b0, now_q} + (TW + 1)'(req_q.io_length);
  assign chg_sum = {1'b0, e_gu} + (NW + 1)'(run_q);
  assign cpu_sum = {1'b0, e_cpu} + (NW + 1)'(run_q);

  fss_prio_unit #(
    .CW(CW)
  ) u_prio (
    .cpu_i      (e_cpu),
    .gu_i       (e_gu),
    .base_i     (base_q[idx_q]),
    .groups_i   (groups_q),
    .cpu_half_o (pu_cpu),
    .gu_half_o  (pu_gu),
    .prio_o     (pu_prio)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_i.req_type)
            fss_pkg::REQ_LOAD:  state_d = slot_ok ? S_LOAD : S_RESP;
            fss_pkg::REQ_ADMIT: state_d = S_ADM;
            fss_pkg::REQ_PICK:  state_d = S_PICK;
            fss_pkg::REQ_EXEC:  state_d = slot_ok ? S_EXCHK : S_RESP;
            fss_pkg::REQ_EARLY: state_d = S_EARLY;
            default:            state_d = S_RESP;
          endcase
        end
      end
      S_LOAD:   state_d = S_RESP;
      S_ADM:    if (last && !nb_found) state_d = S_BIOF;
      S_BIOF:   if (last) state_d = nb_found ? S_BIOD : S_RESP;
      S_BIOD:   if (last) state_d = S_BIOF;
      S_PICK:   if (last) state_d = S_RESP;
      S_EARLY:  if (last) state_d = S_RESP;
      S_EXCHK:  state_d = (e_v && e_r) ? S_EXCHG : S_RESP;
      S_EXCHG:  if (last) state_d = S_EXUPD;
      S_EXUPD:  state_d = S_EXGRP;
      S_EXGRP:  if (last) state_d = S_EXPRIO;
      S_EXPRIO: if (last) state_d = S_RESP;
      S_RESP:   if (res_ack_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      counter_q <= '0;
      idx_q     <= '0;
      for (int i = 0; i < MaxJobs; i++) begin
        slot_valid_q[i] <= 1'b0;
        in_ready_q[i]   <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            idx_q <= (req_i.req_type == fss_pkg::REQ_LOAD ||
                      req_i.req_type == fss_pkg::REQ_EXEC) ? slot_idx : '0;
          end
        end
        S_LOAD: begin
          slot_valid_q[idx_q] <= 1'b1;
          in_ready_q[idx_q]   <= 1'b0;
          counter_q           <= counter_q + 1'b1;
        end
        S_ADM: begin
          idx_q <= last ? '0 : idx_q + 1'b1;
          if (last && nb_found) begin
            in_ready_q[nb_idx] <= 1'b1;
            counter_q          <= counter_q + 1'b1;
          end
        end
        S_BIOF, S_BIOD, S_PICK, S_EARLY, S_EXCHG, S_EXGRP, S_EXPRIO: begin
          idx_q <= last ? (state_q == S_EXCHG ? tgt_q : '0) : idx_q + 1'b1;
        end
        S_EXCHK: begin
          idx_q <= '0;
        end
        S_EXUPD: begin
          idx_q <= '0;
          if (done_q) begin
            if (req_q.is_last_burst) begin
              slot_valid_q[idx_q] <= 1'b0;
              in_ready_q[idx_q]   <= 1'b0;
            end else begin
              in_ready_q[idx_q] <= 1'b0;
              counter_q         <= counter_q + 1'b1;
            end
          end
        end
        default: begin
          idx_q <= idx_q;
        end
      endcase
    end
  end

  // payload and table contents
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_q  <= req_i;
          res_q  <= res_init;
          bf_q   <= 1'b0;
          snap_q <= counter_q;
        end
      end
      S_LOAD: begin
        stamp_q[idx_q] <= counter_q;
        grp_q[idx_q]   <= grp_in;
        base_q[idx_q]  <= req_q.base_priority;
        arr_q[idx_q]   <= req_q.time_value;
        burst_q[idx_q] <= req_q.burst_length;
        cpu_q[idx_q]   <= '0;
        gu_q[idx_q]    <= '0;
        prio_q[idx_q]  <= fss_pkg::PRIO_W'(req_q.base_priority);
        bio_q[idx_q]   <= 1'b0;
      end
      S_ADM, S_BIOF, S_BIOD, S_PICK, S_EARLY: begin
        if (!last) begin
          bf_q   <= nb_found;
          bidx_q <= nb_idx;
          bval_q <= nb_val;
          if (take) bage_q <= e_age;
        end else begin
          bf_q <= 1'b0;
          if (state_q == S_ADM && nb_found) stamp_q[nb_idx] <= counter_q;
          if (state_q == S_BIOF && nb_found) begin
            bio_idx_q <= nb_idx;
            bio_grp_q <= nb_val[GW-1:0];
          end
          if (state_q == S_BIOD) begin
            gu_q[bio_idx_q]  <= nb_found ? nb_val[NW-1:0] : '0;
            bio_q[bio_idx_q] <= 1'b0;
          end
          if (state_q == S_PICK) begin
            res_q.found        <= nb_found;
            res_q.slot_out     <= nb_found ? 4'(nb_idx) : 4'd0;
            res_q.priority_out <= nb_found ? nb_val[fss_pkg::PRIO_W-1:0] : '0;
          end
          if (state_q == S_EARLY) begin
            res_q.found        <= nb_found;
            res_q.next_arrival <= nb_found ? nb_val : fss_pkg::TIME_MAX;
          end
        end
      end
      S_EXCHK: begin
        run_q  <= run_c;
        done_q <= e_burst <= time_slice_i;
        tgt_q  <= idx_q;
        tgrp_q <= e_grp;
        now_q  <= now_sum[TW] ? fss_pkg::TIME_MAX : now_sum[TW-1:0];
      end
      S_EXCHG: begin
        if (e_v && e_r && e_grp == tgrp_q) begin
          gu_q[idx_q] <= chg_sum[NW] ? fss_pkg::CNT_MAX : chg_sum[NW-1:0];
        end
      end
      S_EXUPD: begin
        res_q.new_time <= now_q;
        groups_q       <= '0;
        seen_q         <= '0;
        if (done_q) begin
          res_q.burst_finished <= 1'b1;
          res_q.job_done       <= req_q.is_last_burst;
          if (!req_q.is_last_burst) begin
            arr_q[idx_q]   <= io_sum[TW] ? fss_pkg::TIME_MAX : io_sum[TW-1:0];
            prio_q[idx_q]  <= fss_pkg::PRIO_W'(base_q[idx_q]);
            cpu_q[idx_q]   <= '0;
            gu_q[idx_q]    <= '0;
            bio_q[idx_q]   <= 1'b1;
            burst_q[idx_q] <= req_q.burst_length;
            stamp_q[idx_q] <= counter_q;
          end
        end else begin
          burst_q[idx_q] <= e_burst - run_q;
          cpu_q[idx_q]   <= cpu_sum[NW] ? fss_pkg::CNT_MAX : cpu_sum[NW-1:0];
        end
      end
      S_EXGRP: begin
        // count each group once
        if (e_qual && !seen_q[e_grp]) begin
          seen_q[e_grp] <= 1'b1;
          groups_q      <= groups_q + 1'b1;
        end
      end
      S_EXPRIO: begin
        if (e_qual) begin
          cpu_q[idx_q]  <= pu_cpu;
          gu_q[idx_q]   <= pu_gu;
          prio_q[idx_q] <= pu_prio;
        end
      end
      default: begin
        bf_q <= bf_q;
      end
    endcase
  end

  assign stat_o.idle      = (state_q == S_IDLE);
  assign stat_o.res_valid = (state_q == S_RESP);
  assign res_o            = res_q;

endmodule

// ===== rtl/fair_share_priority_scheduler_core.sv =====
`timescale 1ns / 1ps
// Load writes one slot; pick and earliest scan the table once; execute runs
// charge, group count and priority scans; admit scans once per arrival
// admitted and once more, then twice per job back from I/O and once more.
// One request at a time; the next is accepted once the result is loaded.
// A request is taken while a result waits. Reset clears all valid bits, the
// stamp counter and sets time_slice to 10 at once; no clearing pass.
// ----------------------------------------------------------------------------
// fair_share_priority_scheduler_core
// Top level: configuration register, request channel, result register.
// ----------------------------------------------------------------------------
module fair_share_priority_scheduler_core #(
  parameter int unsigned MAX_JOBS   = fss_pkg::MAX_JOBS_DEF,
  parameter int unsigned MAX_GROUPS = fss_pkg::MAX_GROUPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fss_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fss_pkg::out_res_t out_data_o
);

  logic [fss_pkg::SLICE_W-1:0] time_slice_q;
  logic                        out_valid_q, out_valid_d;
  fss_pkg::out_res_t           out_q;
  fss_pkg::seq_stat_t          stat;
  fss_pkg::out_res_t           res;
  logic                        reg0_sel, load_out, start;

  assign pready   = 1'b1;
  assign reg0_sel = (paddr[2] == 1'b0);
  assign prdata   = reg0_sel ? 32'(time_slice_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_slice_q <= fss_pkg::SLICE_RESET;
    end else if (psel && penable && pwrite && reg0_sel) begin
      time_slice_q <= pwdata[fss_pkg::SLICE_W-1:0];
    end
  end

  assign start      = in_valid_i && stat.idle;
  assign in_stall_o = !stat.idle;

  fss_seq #(
    .MaxJobs  (MAX_JOBS),
    .MaxGroups(MAX_GROUPS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_i        (in_data_i),
    .time_slice_i (time_slice_q),
    .res_ack_i    (load_out),
    .stat_o       (stat),
    .res_o        (res)
  );

  assign load_out    = stat.res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/fss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module fss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fss_pkg::out_res_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while not going busy");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  a_done_implies_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.job_done |-> out_data_o.burst_finished)
    else $error("job_done without burst_finished");

endmodule

bind fair_share_priority_scheduler_core fss_checker u_fss_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fair-share scheduler testbench
// Sends load, admit, pick, execute, earliest and junk requests through the request
// channel, predicts every result with a cycle-free model of the job table, and
// checks each result field by field. time_slice is set over several phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NJ = 16;
  localparam int TW = fss_pkg::TIME_W;
  localparam int NW = fss_pkg::CNT_W;
  localparam int PW = fss_pkg::PRIO_W;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  fss_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  fss_pkg::out_res_t out_data;

  fair_share_priority_scheduler_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // scheduler shadow state
  logic [15:0]   slice_q;
  bit            job_live [NJ];
  bit            job_rdy [NJ];
  logic [15:0]   job_stamp [NJ];
  logic [15:0]   stamp_next;
  logic [3:0]    job_grp [NJ];
  logic [6:0]    job_base [NJ];
  logic [TW-1:0] job_arr [NJ];
  logic [15:0]   job_left [NJ];
  logic [NW-1:0] job_cpu [NJ];
  logic [NW-1:0] job_gusage [NJ];
  logic [PW-1:0] job_prio [NJ];
  bit            job_io [NJ];

  fss_pkg::in_req_t  pending_q[$];
  fss_pkg::out_res_t owed_results[$];
  int       fail_cnt = 0;
  int       req_cnt[8];
  int       res_cnt = 0;
  bit       calm = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;

  function automatic longint unsigned sat(longint unsigned v, longint unsigned mx);
    return (v > mx) ? mx : v;
  endfunction

  function automatic void enqueue(int i, bit rdy);
    job_rdy[i] = rdy;
    job_stamp[i] = stamp_next;
    stamp_next = stamp_next + 16'd1;
  endfunction

  // slots of one queue, oldest entry first
  function automatic int queue_order(bit rdy, ref int lst[NJ]);
    int n;
    int k;
    logic [15:0] ai;
    logic [15:0] ak;
    n = 0;
    for (int i = 0; i < NJ; i++) begin
      if (!job_live[i] || job_rdy[i] != rdy) continue;
      k = n;
      n++;
      ai = stamp_next - job_stamp[i];
      while (k > 0) begin
        ak = stamp_next - job_stamp[lst[k-1]];
        if (ak >= ai) break;
        lst[k] = lst[k-1];
        k--;
      end
      lst[k] = i;
    end
    return n;
  endfunction

  function automatic void reprioritize(logic [TW-1:0] prev);
    longint unsigned groups;
    longint unsigned p;
    bit seen;
    groups = 0;
    for (int i = 0; i < NJ; i++) begin
      if (!job_live[i] || !job_rdy[i] || job_arr[i] > prev) continue;
      seen = 0;
      for (int j = 0; j < i; j++)
        if (job_live[j] && job_rdy[j] && job_arr[j] <= prev && job_grp[j] == job_grp[i])
          seen = 1;
      if (!seen) groups++;
    end
    for (int i = 0; i < NJ; i++) begin
      if (!job_live[i] || !job_rdy[i] || job_arr[i] > prev) continue;
      job_cpu[i] = job_cpu[i] >> 1;
      job_gusage[i] = job_gusage[i] >> 1;
      p = 64'(job_base[i]) + 64'(job_cpu[i] >> 1) +
          (64'(job_gusage[i]) * groups) / 4;
      job_prio[i] = PW'(sat(p, 64'(fss_pkg::PRIO_MAX)));
    end
  endfunction

  function automatic fss_pkg::out_res_t schedule_step(fss_pkg::in_req_t r);
    fss_pkg::out_res_t o;
    int lst[NJ];
    int n;
    int i;
    int s;
    longint unsigned run;
    logic [TW-1:0] now;
    bit fin;
    o = '0;
    s = r.slot;
    case (r.req_type)
      fss_pkg::REQ_LOAD: begin
        job_live[s] = 1;
        job_grp[s] = r.group_id;
        job_base[s] = r.base_priority;
        job_arr[s] = r.time_value;
        job_left[s] = r.burst_length;
        job_cpu[s] = '0;
        job_gusage[s] = '0;
        job_prio[s] = PW'(r.base_priority);
        job_io[s] = 0;
        enqueue(s, 0);
      end
      fss_pkg::REQ_ADMIT: begin
        n = queue_order(0, lst);
        for (int k = 0; k < n; k++)
          if (job_arr[lst[k]] <= r.time_value) enqueue(lst[k], 1);
        n = queue_order(1, lst);
        for (int k = 0; k < n; k++) begin
          i = lst[k];
          if (!job_io[i]) continue;
          job_gusage[i] = '0;
          for (int m = 0; m < n; m++) begin
            if (job_grp[lst[m]] == job_grp[i] && !job_io[lst[m]]) begin
              job_gusage[i] = job_gusage[lst[m]];
              break;
            end
          end
          job_io[i] = 0;
        end
      end
      fss_pkg::REQ_PICK: begin
        n = queue_order(1, lst);
        for (int k = 0; k < n; k++) begin
          i = lst[k];
          if (!o.found || job_prio[i] < o.priority_out) begin
            o.found = 1'b1;
            o.slot_out = 4'(i);
            o.priority_out = job_prio[i];
          end
        end
      end
      fss_pkg::REQ_EXEC: begin
        o.new_time = r.time_value;
        if (job_live[s] && job_rdy[s]) begin
          run = 64'(job_left[s]);
          fin = run <= 64'(slice_q);
          if (!fin) run = 64'(slice_q);
          for (int j = 0; j < NJ; j++)
            if (job_live[j] && job_rdy[j] && job_grp[j] == job_grp[s])
              job_gusage[j] = NW'(sat(64'(job_gusage[j]) + run, 64'(fss_pkg::CNT_MAX)));
          now = TW'(sat(64'(r.time_value) + run, 64'(fss_pkg::TIME_MAX)));
          o.new_time = now;
          if (fin) begin
            o.burst_finished = 1'b1;
            if (r.is_last_burst) begin
              o.job_done = 1'b1;
              job_live[s] = 0;
              job_rdy[s] = 0;
            end else begin
              job_arr[s] = TW'(sat(64'(now) + 64'(r.io_length), 64'(fss_pkg::TIME_MAX)));
              job_prio[s] = PW'(job_base[s]);
              job_cpu[s] = '0;
              job_gusage[s] = '0;
              job_io[s] = 1;
              job_left[s] = r.burst_length;
              enqueue(s, 0);
            end
          end else begin
            job_left[s] = 16'(64'(job_left[s]) - run);
            job_cpu[s] = NW'(sat(64'(job_cpu[s]) + run, 64'(fss_pkg::CNT_MAX)));
          end
          reprioritize(r.prev_decision_point);
        end
      end
      fss_pkg::REQ_EARLY: begin
        o.next_arrival = fss_pkg::TIME_MAX;
        for (int j = 0; j < NJ; j++) begin
          if (job_live[j] && !job_rdy[j]) begin
            if (!o.found || job_arr[j] < o.next_arrival) o.next_arrival = job_arr[j];
            o.found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        owed_results.push_back(schedule_step(in_data));
        req_cnt[in_data.req_type]++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && (calm || $urandom_range(0, 7) != 0)) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (!calm && pending_q.size() > 0) gap_left = $urandom_range(0, 3);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    fss_pkg::out_res_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        res_cnt++;
        if (owed_results.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          fail_cnt++;
        end else begin
          e = owed_results.pop_front();
          if (out_data.found !== e.found) begin
            $error("found exp %0d got %0d", e.found, out_data.found); fail_cnt++;
          end
          if (out_data.slot_out !== e.slot_out) begin
            $error("slot_out exp %0d got %0d", e.slot_out, out_data.slot_out); fail_cnt++;
          end
          if (out_data.priority_out !== e.priority_out) begin
            $error("priority_out exp %0d got %0d", e.priority_out, out_data.priority_out);
            fail_cnt++;
          end
          if (out_data.new_time !== e.new_time) begin
            $error("new_time exp %0d got %0d", e.new_time, out_data.new_time); fail_cnt++;
          end
          if (out_data.burst_finished !== e.burst_finished) begin
            $error("burst_finished exp %0d got %0d", e.burst_finished,
                   out_data.burst_finished);
            fail_cnt++;
          end
          if (out_data.job_done !== e.job_done) begin
            $error("job_done exp %0d got %0d", e.job_done, out_data.job_done); fail_cnt++;
          end
          if (out_data.next_arrival !== e.next_arrival) begin
            $error("next_arrival exp %0d got %0d", e.next_arrival, out_data.next_arrival);
            fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || owed_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_slice(logic [15:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    slice_q = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic fss_pkg::in_req_t mk(logic [2:0] t, int s, int g, int b, int tv,
                                          int pv, int bl, int io, bit last);
    fss_pkg::in_req_t r;
    r.req_type = t; r.slot = 4'(s); r.group_id = 4'(g); r.base_priority = 7'(b);
    r.time_value = TW'(tv); r.prev_decision_point = TW'(pv); r.burst_length = 16'(bl);
    r.io_length = 16'(io); r.is_last_burst = last;
    return r;
  endfunction

  logic [TW-1:0] now_t;

  function automatic fss_pkg::in_req_t rand_req();
    fss_pkg::in_req_t r;
    int pick;
    r = '0;
    r.slot = 4'($urandom_range(0, 15));
    r.group_id = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 3));
    r.base_priority = 7'($urandom_range(0, 127));
    r.burst_length = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535)
                                                     : $urandom_range(1, 40));
    r.io_length = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 50));
    r.is_last_burst = ($urandom_range(0, 2) == 0);
    now_t = TW'(sat(64'(now_t) + 64'($urandom_range(0, 30)), 64'(fss_pkg::TIME_MAX)));
    r.time_value = now_t;
    r.prev_decision_point = (now_t > 20) ? TW'(now_t - TW'($urandom_range(0, 20))) : now_t;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      r.req_type = fss_pkg::REQ_LOAD;
      r.time_value = TW'(sat(64'(now_t) + 64'($urandom_range(0, 40)),
                             64'(fss_pkg::TIME_MAX)));
    end else if (pick < 45) r.req_type = fss_pkg::REQ_ADMIT;
    else if (pick < 65) r.req_type = fss_pkg::REQ_PICK;
    else if (pick < 90) r.req_type = fss_pkg::REQ_EXEC;
    else if (pick < 97) r.req_type = fss_pkg::REQ_EARLY;
    else begin
      // junk requests and odd field values
      r.req_type = 3'($urandom_range(5, 7));
      r.time_value = TW'($urandom_range(0, 24'hFFFFFF));
      r.prev_decision_point = TW'($urandom_range(0, 24'hFFFFFF));
    end
    return r;
  endfunction

  initial begin
    logic [15:0] slices[5];
    slice_q = fss_pkg::SLICE_RESET;
    stamp_next = '0;
    for (int i = 0; i < NJ; i++) begin
      job_live[i] = 0; job_rdy[i] = 0;
    end
    for (int i = 0; i < 8; i++) req_cnt[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queues, extremes, replacement, saturation, junk codes
    pending_q.push_back(mk(fss_pkg::REQ_PICK, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EARLY, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_LOAD, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_LOAD, 15, 15, 127, 24'hFFFFFF, 24'hFFFFFF,
                           65535, 65535, 1));
    pending_q.push_back(mk(fss_pkg::REQ_LOAD, 3, 0, 5, 2, 0, 30, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EXEC, 0, 0, 0, 5, 5, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EARLY, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_ADMIT, 0, 0, 0, 10, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_PICK, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EXEC, 0, 0, 0, 10, 10, 20, 5, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EXEC, 3, 0, 0, 11, 11, 20, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_PICK, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_ADMIT, 0, 0, 0, 20, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_PICK, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_LOAD, 3, 9, 64, 21, 0, 100, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EXEC, 7, 0, 0, 30, 30, 1, 0, 1));
    pending_q.push_back(mk(3'd5, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(3'd6, 15, 15, 127, 24'hFFFFFF, 24'hFFFFFF, 65535, 65535, 1));
    pending_q.push_back(mk(3'd7, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_ADMIT, 0, 0, 0, 24'hFFFFFF, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EXEC, 15, 0, 0, 24'hFFFFF8, 24'hFFFFFF,
                           9, 65535, 0));
    pending_q.push_back(mk(fss_pkg::REQ_PICK, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EARLY, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(fss_pkg::REQ_EXEC, 0, 0, 0, 40, 40, 1, 65535, 1));
    drain();

    slices[0] = 16'd1;
    slices[1] = 16'd65535;
    slices[2] = 16'($urandom_range(2, 65534));
    slices[3] = 16'd3;
    slices[4] = 16'd10;
    for (int ph = 0; ph < 5; ph++) begin
      set_slice(slices[ph]);
      // one phase runs close to the end of the time range
      now_t = (ph == 2) ? 24'hFFF000 : 24'd50;
      if (ph == 4) calm = 1'b1;
      for (int k = 0; k < 316; k++) pending_q.push_back(rand_req());
      drain();
    end

    $display("requests: load %0d admit %0d pick %0d exec %0d early %0d other %0d",
             req_cnt[0], req_cnt[1], req_cnt[2], req_cnt[3], req_cnt[4],
             req_cnt[5] + req_cnt[6] + req_cnt[7]);
    $display("%0d results checked over six time_slice settings", res_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fss_pkg.sv
rtl/fss_prio_unit.sv
rtl/fss_seq.sv
rtl/fair_share_priority_scheduler_core.sv
rtl/fss_checker.sv
verif/testbench.sv
